/* hdl/mcsg_pkg.sv */
// Shared types and constants for the midpoint circle span generator.
`timescale 1ns / 1ps

package mcsg_pkg;

  localparam int COORD_BITS = 16;
  localparam int SPAN_BITS  = 16;
  localparam int COLOR_BITS = 16;
  localparam int MAX_SPANS  = 8;
  localparam int IDX_BITS   = $clog2(MAX_SPANS);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam logic [IDX_BITS-1:0] LAST_FINISHED = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] LAST_FILL     = IDX_BITS'(3);
  localparam logic [IDX_BITS-1:0] LAST_OUTLINE  = IDX_BITS'(MAX_SPANS - 1);

  localparam logic [COORD_BITS-1:0] DEC_INIT      = COORD_BITS'(3);
  localparam logic [COORD_BITS-1:0] DEC_DIAG_INC  = COORD_BITS'(10);
  localparam logic [COORD_BITS-1:0] DEC_STRAIGHT  = COORD_BITS'(6);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                  func;
    logic [SPAN_BITS-1:0]  center_x;
    logic [SPAN_BITS-1:0]  center_y;
    logic [SPAN_BITS-1:0]  radius;
    logic [COLOR_BITS-1:0] draw_color;
    logic                  fill_mode;
  } cmd_word_t;

  typedef struct packed {
    logic [SPAN_BITS-1:0]  span_x_start;
    logic [SPAN_BITS-1:0]  span_x_end;
    logic [SPAN_BITS-1:0]  span_row;
    logic [COLOR_BITS-1:0] span_color;
    logic                  is_finished;
    logic                  last;
    logic                  done_res;
  } span_word_t;

  // Snapshot of one step: the point to mirror plus per-step flags.
  typedef struct packed {
    coord_t                cx;
    coord_t                cy;
    coord_t                x;
    coord_t                y;
    logic [COLOR_BITS-1:0] color;
    logic                  fill;
    logic                  fin;
    logic                  done;
  } batch_t;

endpackage

/* hdl/mcsg_stepper.sv */
// Circle state registers and the midpoint decision update.
`timescale 1ns / 1ps

module mcsg_stepper (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  mcsg_pkg::cmd_word_t cmd,
  output logic               load,
  output mcsg_pkg::batch_t   batch
);

  mcsg_pkg::coord_t step_x, step_y, decision, origin_x, origin_y;
  mcsg_pkg::coord_t step_x_next, step_y_next, decision_next, radius_c;
  logic [mcsg_pkg::COLOR_BITS-1:0] held_color;
  logic held_fill, running, running_next;

  assign radius_c = mcsg_pkg::COORD_BITS'(cmd.radius);

  always_comb begin
    step_x_next = step_x + mcsg_pkg::COORD_BITS'(1);
    if (!decision[mcsg_pkg::COORD_BITS-1]) begin
      step_y_next   = step_y - mcsg_pkg::COORD_BITS'(1);
      decision_next = decision + (step_x_next << 2) - (step_y_next << 2)
                      + mcsg_pkg::DEC_DIAG_INC;
    end else begin
      step_y_next   = step_y;
      decision_next = decision + (step_x_next << 2) + mcsg_pkg::DEC_STRAIGHT;
    end
    running_next = step_y_next > step_x_next;
  end

  assign load = accept && (cmd.func == mcsg_pkg::FUNC_STEP);

  always_comb begin
    batch.cx    = origin_x;
    batch.cy    = origin_y;
    batch.x     = step_x;
    batch.y     = step_y;
    batch.color = held_color;
    batch.fill  = held_fill;
    batch.fin   = !running;
    batch.done  = running ? !running_next : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x     <= '0;
      step_y     <= '0;
      decision   <= '0;
      origin_x   <= '0;
      origin_y   <= '0;
      held_color <= '0;
      held_fill  <= 1'b0;
      running    <= 1'b0;
    end else if (accept) begin
      if (cmd.func == mcsg_pkg::FUNC_START) begin
        origin_x   <= mcsg_pkg::COORD_BITS'(cmd.center_x);
        origin_y   <= mcsg_pkg::COORD_BITS'(cmd.center_y);
        held_color <= cmd.draw_color;
        held_fill  <= cmd.fill_mode;
        step_x     <= '0;
        step_y     <= radius_c;
        decision   <= mcsg_pkg::DEC_INIT - (radius_c << 1);
        running    <= (radius_c != '0);
      end else if (running) begin
        step_x   <= step_x_next;
        step_y   <= step_y_next;
        decision <= decision_next;
        running  <= running_next;
      end
    end
  end

endmodule

/* hdl/mcsg_emitter.sv */
// Step snapshot register and per-word span mirroring onto the result channel.
`timescale 1ns / 1ps

module mcsg_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  mcsg_pkg::batch_t    batch,
  output logic                free,
  output logic                span_valid,
  input  logic                span_ready,
  output mcsg_pkg::span_word_t span
);

  mcsg_pkg::batch_t b;
  logic busy;
  logic [mcsg_pkg::IDX_BITS-1:0] idx, last_idx, last_idx_next;
  logic at_last;
  mcsg_pkg::coord_t u, v, col_lo, col_hi, row;

  assign at_last    = (idx == last_idx);
  assign span_valid = busy;
  assign free       = !busy || (span_ready && at_last);

  always_comb begin
    if (batch.fin) begin
      last_idx_next = mcsg_pkg::LAST_FINISHED;
    end else if (batch.fill) begin
      last_idx_next = mcsg_pkg::LAST_FILL;
    end else begin
      last_idx_next = mcsg_pkg::LAST_OUTLINE;
    end
  end

  // Mirror the point: the high index bit (bit 1 in fill) swaps x and y.
  always_comb begin
    if (b.fill) begin
      u      = idx[1] ? b.y : b.x;
      v      = idx[1] ? b.x : b.y;
      col_lo = b.cx - u;
      col_hi = b.cx + u;
      row    = idx[0] ? (b.cy - v) : (b.cy + v);
    end else begin
      u      = idx[2] ? b.y : b.x;
      v      = idx[2] ? b.x : b.y;
      col_lo = idx[0] ? (b.cx - u) : (b.cx + u);
      col_hi = col_lo;
      row    = idx[1] ? (b.cy - v) : (b.cy + v);
    end
  end

  always_comb begin
    span.is_finished = b.fin;
    span.last        = at_last;
    span.done_res    = b.done;
    if (b.fin) begin
      span.span_x_start = '0;
      span.span_x_end   = '0;
      span.span_row     = '0;
      span.span_color   = '0;
    end else begin
      span.span_x_start = mcsg_pkg::SPAN_BITS'(col_lo);
      span.span_x_end   = mcsg_pkg::SPAN_BITS'(col_hi);
      span.span_row     = mcsg_pkg::SPAN_BITS'(row);
      span.span_color   = b.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && span_ready) begin
      busy <= !at_last;
      idx  <= idx + mcsg_pkg::IDX_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b        <= batch;
      last_idx <= last_idx_next;
    end
  end

endmodule

/* hdl/midpoint_circle_span_generator.sv */
// Top level of the midpoint circle span generator.
`timescale 1ns / 1ps

//  channel | handshake              | payload     | direction
//  --------+------------------------+-------------+----------
//  cmd     | cmd_valid / cmd_ready  | cmd_word_t  | in
//  span    | span_valid / span_ready| span_word_t | out
//
//  A start word updates the circle state in the cycle it is taken and makes
//  no result. A step word is snapshotted into the emitter register; the
//  emitter then shows one span word per cycle while span_ready is high: 8 in
//  outline mode, 4 in fill mode, 1 when the circle is finished. Its word
//  count sets the rate. cmd_ready rises again in the cycle the last span
//  word is taken, so steps run back to back. Reset clears the circle state
//  and empties the emitter. A stall on span holds the current word.

module midpoint_circle_span_generator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  mcsg_pkg::cmd_word_t  cmd,
  output logic                 span_valid,
  input  logic                 span_ready,
  output mcsg_pkg::span_word_t span
);

  logic             accept;
  logic             load;
  logic             free;
  mcsg_pkg::batch_t batch;

  // Take a word only when the emitter can capture a fresh step.
  assign cmd_ready = free;
  assign accept    = cmd_valid && cmd_ready;

  // Advance the decision variable and expose the pre-step snapshot.
  mcsg_stepper u_stepper (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .load   (load),
    .batch  (batch)
  );

  // Hold the snapshot and drop out one mirrored span per cycle while span_ready is high.
  mcsg_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .batch      (batch),
    .free       (free),
    .span_valid (span_valid),
    .span_ready (span_ready),
    .span       (span)
  );

endmodule
